[hdl/gpsl_pkg.sv]
`timescale 1ns / 1ps

package gpsl_pkg;

  localparam int DEF_COUNT_WIDTH = 16;
  localparam int DEF_TIME_WIDTH  = 40;

  localparam int PHASE_W      = 48;
  localparam int FREQ_W       = 32;
  localparam int MODE_W       = 2;
  localparam int REC_CNT_W    = 16;
  localparam int PHASE_THR_W  = 47;
  localparam int FREQ_THR_W   = 31;
  localparam int STAB_CNT_W   = 16;
  localparam int CFG_DATA_W   = 47;
  localparam int CFG_IDX_W    = 2;

  localparam logic [MODE_W-1:0] MODE_RECOVERY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCKED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLDOVER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABILITY_COUNT = 2'd3;

  localparam logic [REC_CNT_W-1:0]   RST_RECOVERY_COUNT  = 16'd10;
  localparam logic [PHASE_THR_W-1:0] RST_PHASE_THRESHOLD = 47'd100;
  localparam logic [FREQ_THR_W-1:0]  RST_FREQ_THRESHOLD  = 31'd1280;
  localparam logic [STAB_CNT_W-1:0]  RST_STABILITY_COUNT = 16'd10;

  typedef struct packed {
    logic [REC_CNT_W-1:0]   recovery_count;
    logic [PHASE_THR_W-1:0] phase_threshold;
    logic [FREQ_THR_W-1:0]  freq_threshold;
    logic [STAB_CNT_W-1:0]  stability_count;
  } cfg_t;

  typedef struct packed {
    logic ref_ok;
    logic in_thr;
  } meas_flags_t;

endpackage

[hdl/gpsl_if.sv]
`timescale 1ns / 1ps

interface gpsl_meas_if #(
  parameter int TIME_WIDTH = 40
);
  logic                   valid;
  logic                   ready;
  logic                   pps_ok;
  logic                   tod_ok;
  logic signed [47:0]     phase_err;
  logic signed [31:0]     freq_err;
  logic [TIME_WIDTH-1:0]  utc_seconds;

  modport source (output valid, pps_ok, tod_ok, phase_err, freq_err, utc_seconds,
                  input ready);
  modport sink   (input valid, pps_ok, tod_ok, phase_err, freq_err, utc_seconds,
                  output ready);
endinterface

interface gpsl_res_if #(
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 40
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             servo_mode;
  logic                   stable_lock;
  logic [COUNT_WIDTH-1:0] good_run;
  logic [COUNT_WIDTH-1:0] lock_run;
  logic [TIME_WIDTH-1:0]  seconds_in_mode;

  modport source (output valid, servo_mode, stable_lock, good_run, lock_run,
                  seconds_in_mode, input ready);
  modport sink   (input valid, servo_mode, stable_lock, good_run, lock_run,
                  seconds_in_mode, output ready);
endinterface

[hdl/gpsl_cfg_regs.sv]
`timescale 1ns / 1ps

module gpsl_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gpsl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gpsl_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output gpsl_pkg::cfg_t                        cfg_o
);
  import gpsl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RECOVERY_COUNT:  cfg_d.recovery_count  = cfg_data_i[REC_CNT_W-1:0];
        REG_PHASE_THRESHOLD: cfg_d.phase_threshold = cfg_data_i[PHASE_THR_W-1:0];
        REG_FREQ_THRESHOLD:  cfg_d.freq_threshold  = cfg_data_i[FREQ_THR_W-1:0];
        REG_STABILITY_COUNT: cfg_d.stability_count = cfg_data_i[STAB_CNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recovery_count  <= RST_RECOVERY_COUNT;
      cfg_q.phase_threshold <= RST_PHASE_THRESHOLD;
      cfg_q.freq_threshold  <= RST_FREQ_THRESHOLD;
      cfg_q.stability_count <= RST_STABILITY_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/gpsl_meas_stage.sv]
`timescale 1ns / 1ps

module gpsl_meas_stage #(
  parameter int TIME_WIDTH = gpsl_pkg::DEF_TIME_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gpsl_pkg::cfg_t             cfg_i,
  gpsl_meas_if.sink                  meas_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output gpsl_pkg::meas_flags_t      flags_o,
  output logic [TIME_WIDTH-1:0]      now_o
);
  import gpsl_pkg::*;

  logic                  valid_q, valid_d;
  meas_flags_t           flags_q, flags_d;
  logic [TIME_WIDTH-1:0] now_q;
  logic [PHASE_W-1:0]    pmag;
  logic [FREQ_W-1:0]     fmag;
  logic                  take;

  // A most negative error maps to 2^47 or 2^31, which no threshold reaches.
  assign pmag = meas_i.phase_err[PHASE_W-1] ? (~meas_i.phase_err + 1'b1)
                                            : meas_i.phase_err;
  assign fmag = meas_i.freq_err[FREQ_W-1] ? (~meas_i.freq_err + 1'b1)
                                          : meas_i.freq_err;

  assign meas_i.ready = !valid_q || ready_i;
  assign take         = meas_i.valid && meas_i.ready;

  always_comb begin
    flags_d.ref_ok = meas_i.pps_ok && meas_i.tod_ok;
    flags_d.in_thr = (pmag <= {1'b0, cfg_i.phase_threshold}) &&
                     (fmag <= {1'b0, cfg_i.freq_threshold});
    valid_d        = take || (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flags_q <= flags_d;
      now_q   <= meas_i.utc_seconds;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign now_o   = now_q;

endmodule

[hdl/gpsl_servo_core.sv]
`timescale 1ns / 1ps

module gpsl_servo_core #(
  parameter int COUNT_WIDTH = gpsl_pkg::DEF_COUNT_WIDTH,
  parameter int TIME_WIDTH  = gpsl_pkg::DEF_TIME_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gpsl_pkg::cfg_t             cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  gpsl_pkg::meas_flags_t      flags_i,
  input  logic [TIME_WIDTH-1:0]      now_i,
  gpsl_res_if.source                 res_o
);
  import gpsl_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > REC_CNT_W) ? COUNT_WIDTH : REC_CNT_W;

  logic [MODE_W-1:0]      mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] good_q, good_d;
  logic [COUNT_WIDTH-1:0] lock_q, lock_d;
  logic [TIME_WIDTH-1:0]  ctime_q, ctime_d;
  logic                   out_valid_q, out_valid_d;
  logic                   stable_d;
  logic [TIME_WIDTH-1:0]  secs_d;
  logic [COUNT_WIDTH-1:0] good_inc;
  logic [COUNT_WIDTH-1:0] lock_inc;
  logic                   take;

  logic [MODE_W-1:0]      res_mode_q;
  logic                   res_stable_q;
  logic [COUNT_WIDTH-1:0] res_good_q;
  logic [COUNT_WIDTH-1:0] res_lock_q;
  logic [TIME_WIDTH-1:0]  res_secs_q;

  assign ready_o = !out_valid_q || res_o.ready;
  assign take    = valid_i && ready_o;

  assign good_inc = (&good_q) ? good_q : good_q + 1'b1;
  assign lock_inc = (&lock_q) ? lock_q : lock_q + 1'b1;

  always_comb begin
    mode_d  = mode_q;
    good_d  = good_q;
    lock_d  = lock_q;
    // An unset change time picks up the current stamp first.
    ctime_d = (ctime_q == '0) ? now_i : ctime_q;
    case (mode_q)
      MODE_LOCKED: begin
        if (!flags_i.ref_ok) begin
          mode_d  = MODE_HOLDOVER;
          ctime_d = now_i;
        end else if (flags_i.in_thr) begin
          lock_d = lock_inc;
        end else begin
          lock_d = '0;
        end
      end
      MODE_HOLDOVER: begin
        if (flags_i.ref_ok) begin
          mode_d  = MODE_RECOVERY;
          ctime_d = now_i;
          good_d  = '0;
        end
      end
      default: begin
        if (flags_i.ref_ok) begin
          good_d = good_inc;
          if (CMP_W'(good_inc) >= CMP_W'(cfg_i.recovery_count)) begin
            mode_d  = MODE_LOCKED;
            ctime_d = now_i;
            lock_d  = '0;
          end
        end else begin
          good_d = '0;
        end
      end
    endcase
    stable_d    = (mode_d == MODE_LOCKED) &&
                  (CMP_W'(lock_d) >= CMP_W'(cfg_i.stability_count));
    secs_d      = (ctime_d == '0) ? '0 : now_i - ctime_d;
    out_valid_d = take || (out_valid_q && !res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RECOVERY;
      good_q      <= '0;
      lock_q      <= '0;
      ctime_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        mode_q  <= mode_d;
        good_q  <= good_d;
        lock_q  <= lock_d;
        ctime_q <= ctime_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_mode_q   <= mode_d;
      res_stable_q <= stable_d;
      res_good_q   <= good_d;
      res_lock_q   <= lock_d;
      res_secs_q   <= secs_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.servo_mode      = res_mode_q;
  assign res_o.stable_lock     = res_stable_q;
  assign res_o.good_run        = res_good_q;
  assign res_o.lock_run        = res_lock_q;
  assign res_o.seconds_in_mode = res_secs_q;

endmodule

[hdl/gps_servo_lock_state_machine.sv]
`timescale 1ns / 1ps
// A measurement accepted by the measurement stage is registered there, and its result
// is loaded into the result register once that register is free.
// Throughput: one measurement per clock cycle while the result output is not stalled.
// Reset (asynchronous, active low) returns the servo to recovery with both counters at
// zero, the change time unset, no request pending and the config registers at defaults.
module gps_servo_lock_state_machine #(
  parameter int COUNT_WIDTH = gpsl_pkg::DEF_COUNT_WIDTH,
  parameter int TIME_WIDTH  = gpsl_pkg::DEF_TIME_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gpsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gpsl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  gpsl_meas_if.sink                         meas_i,
  gpsl_res_if.source                        res_o
);
  import gpsl_pkg::*;

  cfg_t                  cfg;
  logic                  stage_valid;
  logic                  core_ready;
  meas_flags_t           stage_flags;
  logic [TIME_WIDTH-1:0] stage_now;

  gpsl_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gpsl_meas_stage #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_meas_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .meas_i  (meas_i),
    .valid_o (stage_valid),
    .ready_i (core_ready),
    .flags_o (stage_flags),
    .now_o   (stage_now)
  );

  gpsl_servo_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_servo_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (stage_valid),
    .ready_o (core_ready),
    .flags_i (stage_flags),
    .now_i   (stage_now),
    .res_o   (res_o)
  );

endmodule

[hdl/gpsl_checker.sv]
`timescale 1ns / 1ps

module gpsl_checker #(
  parameter int COUNT_WIDTH = gpsl_pkg::DEF_COUNT_WIDTH,
  parameter int TIME_WIDTH  = gpsl_pkg::DEF_TIME_WIDTH
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [1:0]             servo_mode_i,
  input logic                   stable_lock_i,
  input logic [COUNT_WIDTH-1:0] good_run_i,
  input logic [COUNT_WIDTH-1:0] lock_run_i,
  input logic [TIME_WIDTH-1:0]  seconds_in_mode_i
);
  import gpsl_pkg::*;

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (servo_mode_i == MODE_RECOVERY) || (servo_mode_i == MODE_LOCKED) ||
                    (servo_mode_i == MODE_HOLDOVER))
    else $error("servo mode code out of range");

  a_stable_needs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && stable_lock_i) |-> (servo_mode_i == MODE_LOCKED))
    else $error("stable lock reported outside locked mode");

  a_holdover_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && servo_mode_i == MODE_HOLDOVER) |-> !stable_lock_i)
    else $error("stable lock reported in holdover");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i && $stable(servo_mode_i) &&
      $stable(stable_lock_i) && $stable(good_run_i) && $stable(lock_run_i) &&
      $stable(seconds_in_mode_i))
    else $error("stalled result request changed");

endmodule

bind gps_servo_lock_state_machine gpsl_checker #(
  .COUNT_WIDTH (COUNT_WIDTH),
  .TIME_WIDTH  (TIME_WIDTH)
) u_gpsl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .servo_mode_i      (res_o.servo_mode),
  .stable_lock_i     (res_o.stable_lock),
  .good_run_i        (res_o.good_run),
  .lock_run_i        (res_o.lock_run),
  .seconds_in_mode_i (res_o.seconds_in_mode)
);
